// ===== rtl/mstt_pkg.sv =====
// ----------------------------------------------------------------------------
// mstt_pkg
// shared types and codes for the multi-slot repeat timer
// ----------------------------------------------------------------------------
`default_nettype none

package mstt_pkg;

  localparam logic [1:0] FUNC_ARM    = 2'd0;
  localparam logic [1:0] FUNC_FREE   = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic signed [16:0] LOOP_FOREVER = -17'sd1;
  localparam logic signed [16:0] LOOP_ONE     = 17'sd1;

  // request as held in the front queue
  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         slot;
    logic               slot_ok;
    logic [30:0]        period_ms;
    logic signed [16:0] loop_count;
    logic [31:0]        now_ms;
  } cmd_t;

  // one result item without count and last marker
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       expired;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/multi_slot_repeat_timer.sv =====
// ----------------------------------------------------------------------------
// multi_slot_repeat_timer
// table of repeating millisecond timer slots
// ----------------------------------------------------------------------------
// requests arm a slot, free a slot, or update the table at a millisecond
// time. an arm or free accepted into an empty queue shows its single
// acknowledge once it has passed the result buffer and the output register.
// an update walks every slot in ascending order: an idle slot takes only
// the read state, an armed one the read state (payload memory read) and
// then the evaluate state (compare and write back); a closing result
// follows. results of a request are buffered and shown only once the
// whole request is done, so active_count is the count after the request;
// the next request starts only after all its results are popped. a
// two-entry request queue lets push continue while the scan runs.
`default_nettype none

module multi_slot_repeat_timer #(
  parameter int NUM_SLOTS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  // request side
  input  wire               push,
  output logic              full,
  input  wire  [1:0]        func_i,
  input  wire  [3:0]        slot_i,
  input  wire  [30:0]       period_ms_i,
  input  wire  signed [16:0] loop_count_i,
  input  wire  [31:0]       now_ms_i,
  // result side
  output logic              empty,
  input  wire               pop,
  output logic [1:0]        kind_o,
  output logic [3:0]        fired_slot_o,
  output logic              expired_o,
  output logic [4:0]        active_count_o,
  output logic              last_o
);
  import mstt_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // front: request queue and slot range check
  mstt_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .slot_i       (slot_i),
    .period_ms_i  (period_ms_i),
    .loop_count_i (loop_count_i),
    .now_ms_i     (now_ms_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // back: slot table, scan engine, result buffer
  mstt_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .fired_slot_o   (fired_slot_o),
    .expired_o      (expired_o),
    .active_count_o (active_count_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/mstt_front.sv =====
// ----------------------------------------------------------------------------
// mstt_front
// accepts requests, checks the slot range and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_front #(
  parameter int NUM_SLOTS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  wire  [1:0]          func_i,
  input  wire  [3:0]          slot_i,
  input  wire  [30:0]         period_ms_i,
  input  wire  signed [16:0]  loop_count_i,
  input  wire  [31:0]         now_ms_i,
  output logic                cmd_valid_o,
  output mstt_pkg::cmd_t      cmd_o,
  input  wire                 cmd_pop_i
);
  import mstt_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    cmd_in.func       = func_i;
    cmd_in.slot       = slot_i;
    cmd_in.slot_ok    = (32'(slot_i) < 32'(NUM_SLOTS));
    cmd_in.period_ms  = period_ms_i;
    cmd_in.loop_count = loop_count_i;
    cmd_in.now_ms     = now_ms_i;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mstt_back.sv =====
// ----------------------------------------------------------------------------
// mstt_back
// slot table, update scan and result buffer
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_back #(
  parameter int NUM_SLOTS = 16
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            cmd_valid_i,
  input  mstt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  input  wire            pop,
  output logic [1:0]     kind_o,
  output logic [3:0]     fired_slot_o,
  output logic           expired_o,
  output logic [4:0]     active_count_o,
  output logic           last_o
);
  import mstt_pkg::*;

  localparam int IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW    = $clog2(NUM_SLOTS + 1);
  localparam int RDEP  = NUM_SLOTS + 1;
  localparam int AW    = $clog2(RDEP);
  localparam int PW    = $clog2(RDEP + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EV    = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]           state_q;
  logic [IW-1:0]        idx_q;
  logic [NUM_SLOTS-1:0] armed_q, started_q;
  logic [CW-1:0]        total_q;

  logic [31:0]        tm_start [NUM_SLOTS];
  logic [30:0]        tm_int   [NUM_SLOTS];
  logic signed [16:0] tm_loop  [NUM_SLOTS];
  logic [31:0]        st_rd_q;
  logic [30:0]        int_rd_q;
  logic signed [16:0] loop_rd_q;

  res_t          res_mem [RDEP];
  logic [PW-1:0] res_wr_q, res_rd_q;
  logic          out_v_q, out_last_q;
  res_t          out_q;

  // scan evaluation
  logic [31:0] elapsed;
  logic        fire, reload, is_last_idx, drained, out_load;
  logic [IW-1:0] slot_idx;

  assign slot_idx    = IW'(cmd_i.slot);
  assign is_last_idx = (32'(idx_q) == 32'(NUM_SLOTS - 1));
  assign elapsed     = started_q[idx_q] ? (cmd_i.now_ms - st_rd_q) : 32'd0;
  assign fire        = !(elapsed < {1'b0, int_rd_q});
  assign reload      = (loop_rd_q == LOOP_FOREVER) || (loop_rd_q > LOOP_ONE);
  assign cmd_pop_o   = cmd_valid_i &&
                       (state_q == S_CLOSE || (state_q == S_IDLE &&
                        cmd_i.func != FUNC_UPDATE));
  assign drained     = (res_rd_q == res_wr_q) && !out_v_q;
  assign out_load    = (state_q == S_DRAIN) && (res_rd_q != res_wr_q) &&
                       (!out_v_q || pop);

  // slot payload stores
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.func == FUNC_ARM && cmd_i.slot_ok) begin
      tm_int[slot_idx]  <= cmd_i.period_ms;
      tm_loop[slot_idx] <= cmd_i.loop_count;
    end else if (state_q == S_EV && fire && reload && loop_rd_q != LOOP_FOREVER) begin
      tm_loop[idx_q] <= loop_rd_q - LOOP_ONE;
    end
    if (state_q == S_EV && (!started_q[idx_q] || (fire && reload))) begin
      tm_start[idx_q] <= cmd_i.now_ms;
    end
    if (state_q == S_RD) begin
      st_rd_q   <= tm_start[idx_q];
      int_rd_q  <= tm_int[idx_q];
      loop_rd_q <= tm_loop[idx_q];
    end
  end

  // result buffer
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.func != FUNC_UPDATE) begin
      res_mem[res_wr_q[AW-1:0]] <= '{kind: KIND_ACK, slot: cmd_i.slot, expired: 1'b0};
    end else if (state_q == S_EV && fire) begin
      res_mem[res_wr_q[AW-1:0]] <= '{kind: KIND_FIRED, slot: 4'(idx_q),
                                     expired: !reload};
    end else if (state_q == S_CLOSE) begin
      res_mem[res_wr_q[AW-1:0]] <= '{kind: KIND_CLOSE, slot: 4'd0, expired: 1'b0};
    end
    if (out_load) begin
      out_q      <= res_mem[res_rd_q[AW-1:0]];
      out_last_q <= (res_rd_q + PW'(1) == res_wr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      armed_q   <= '0;
      started_q <= '0;
      total_q   <= '0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_v_q  <= 1'b1;
        res_rd_q <= res_rd_q + PW'(1);
      end else if (pop && out_v_q) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.func == FUNC_UPDATE) begin
              idx_q   <= '0;
              state_q <= S_RD;
            end else begin
              if (cmd_i.slot_ok && cmd_i.func == FUNC_ARM) begin
                if (!armed_q[slot_idx]) total_q <= total_q + CW'(1);
                armed_q[slot_idx]   <= 1'b1;
                started_q[slot_idx] <= 1'b0;
              end else if (cmd_i.slot_ok && cmd_i.func == FUNC_FREE &&
                           armed_q[slot_idx]) begin
                armed_q[slot_idx]   <= 1'b0;
                started_q[slot_idx] <= 1'b0;
                total_q             <= total_q - CW'(1);
              end
              res_wr_q <= res_wr_q + PW'(1);
              state_q  <= S_DRAIN;
            end
          end
        end
        S_RD: begin
          if (armed_q[idx_q]) begin
            state_q <= S_EV;
          end else if (is_last_idx) begin
            state_q <= S_CLOSE;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        S_EV: begin
          started_q[idx_q] <= 1'b1;
          if (fire) begin
            res_wr_q <= res_wr_q + PW'(1);
            if (!reload) begin
              armed_q[idx_q]   <= 1'b0;
              started_q[idx_q] <= 1'b0;
              total_q          <= total_q - CW'(1);
            end
          end
          if (is_last_idx) begin
            state_q <= S_CLOSE;
          end else begin
            idx_q   <= idx_q + IW'(1);
            state_q <= S_RD;
          end
        end
        S_CLOSE: begin
          res_wr_q <= res_wr_q + PW'(1);
          state_q  <= S_DRAIN;
        end
        S_DRAIN: begin
          if (drained) begin
            res_wr_q <= '0;
            res_rd_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign empty          = !out_v_q;
  assign kind_o         = out_q.kind;
  assign fired_slot_o   = out_q.slot;
  assign expired_o      = out_q.expired;
  assign last_o         = out_last_q;
  assign active_count_o = 5'(total_q);

endmodule

`default_nettype wire
